/* rtl/epg_pkg.sv */
// Shared constants, widths and the arctangent table of the epicycloid point generator.
// Depends on nothing; every other file of the block imports it.
package epg_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

   localparam int RADIUS_W = 16;
   localparam int SUM_W = RADIUS_W + 1;
   localparam int ANGLE_W = 27;
   localparam int POINT_W = 19;
   localparam int DIVIDEND_W = 60;
   localparam int MOD_W = 35;
   localparam int PHASE_W = MOD_W - 2;
   localparam int CORD_W = 35;
   localparam int PROD_W = CORD_W + SUM_W + 1;

   localparam logic [MOD_W-1:0] TWO_PI_Q32 = 35'd26986075409;
   localparam logic signed [CORD_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [CORD_W-1:0] TWO_PI_Q30 = 35'sd6746518852;
   localparam logic signed [CORD_W-1:0] INV_GAIN_Q30 = 35'sd652032874;

   localparam logic [1:0] REG_ROLLING = 2'd0;
   localparam logic [1:0] REG_FIXED = 2'd1;

   function automatic logic signed [CORD_W-1:0] atan_q30(input int idx);
      logic signed [CORD_W-1:0] v;
      case (idx)
         0: v = 35'sd843314857;
         1: v = 35'sd497837830;
         2: v = 35'sd263043837;
         3: v = 35'sd133525159;
         4: v = 35'sd67021687;
         5: v = 35'sd33543516;
         6: v = 35'sd16775851;
         7: v = 35'sd8388437;
         8: v = 35'sd4194283;
         9: v = 35'sd2097149;
         10: v = 35'sd1048576;
         11: v = 35'sd524288;
         12: v = 35'sd262144;
         13: v = 35'sd131072;
         14: v = 35'sd65536;
         15: v = 35'sd32768;
         16: v = 35'sd16384;
         17: v = 35'sd8192;
         18: v = 35'sd4096;
         19: v = 35'sd2048;
         20: v = 35'sd1024;
         21: v = 35'sd512;
         22: v = 35'sd256;
         23: v = 35'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/epg_divmod.sv */
// Pipelined restoring divider that forms (a+b)*t/a one quotient bit per stage and
// reduces both t and the quotient modulo 2*pi on the fly. Depends on epg_pkg.
module epg_divmod
   import epg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [ANGLE_W-1:0]  in_angle,
   input  logic [RADIUS_W-1:0] rolling_radius,
   input  logic [SUM_W-1:0]    radius_sum,
   output logic                out_valid,
   output logic [PHASE_W-1:0]  out_phase_t,
   output logic [PHASE_W-1:0]  out_phase_c
);

   logic                  valid_ff [0:DIVIDEND_W];
   logic [DIVIDEND_W-1:0] dvd_ff   [0:DIVIDEND_W];
   logic [DIVIDEND_W-1:0] tq_ff    [0:DIVIDEND_W];
   logic [RADIUS_W-1:0]   rem_ff   [0:DIVIDEND_W];
   logic [MOD_W-1:0]      cmod_ff  [0:DIVIDEND_W];
   logic [MOD_W-1:0]      tmod_ff  [0:DIVIDEND_W];

   logic [DIVIDEND_W-1:0] dvd_in   [1:DIVIDEND_W];
   logic [DIVIDEND_W-1:0] tq_in    [1:DIVIDEND_W];
   logic [RADIUS_W-1:0]   rem_in   [1:DIVIDEND_W];
   logic [MOD_W-1:0]      cmod_in  [1:DIVIDEND_W];
   logic [MOD_W-1:0]      tmod_in  [1:DIVIDEND_W];

   logic [SUM_W-1:0]        prod_rem;
   logic                    qbit;
   logic [MOD_W:0]          cmod2;
   logic [MOD_W:0]          tmod2;
   logic [SUM_W+ANGLE_W-1:0] product;

   assign product = radius_sum * in_angle;

   always_comb begin
      prod_rem = '0;
      qbit = 1'b0;
      cmod2 = '0;
      tmod2 = '0;
      for (int k = 0; k < DIVIDEND_W; k++) begin
         prod_rem = {rem_ff[k], dvd_ff[k][DIVIDEND_W-1]};
         if (prod_rem >= {1'b0, rolling_radius}) begin
            rem_in[k+1] = RADIUS_W'(prod_rem - {1'b0, rolling_radius});
            qbit = 1'b1;
         end else begin
            rem_in[k+1] = prod_rem[RADIUS_W-1:0];
            qbit = 1'b0;
         end
         cmod2 = {cmod_ff[k], qbit};
         if (cmod2 >= {1'b0, TWO_PI_Q32}) begin
            cmod_in[k+1] = MOD_W'(cmod2 - {1'b0, TWO_PI_Q32});
         end else begin
            cmod_in[k+1] = cmod2[MOD_W-1:0];
         end
         tmod2 = {tmod_ff[k], tq_ff[k][DIVIDEND_W-1]};
         if (tmod2 >= {1'b0, TWO_PI_Q32}) begin
            tmod_in[k+1] = MOD_W'(tmod2 - {1'b0, TWO_PI_Q32});
         end else begin
            tmod_in[k+1] = tmod2[MOD_W-1:0];
         end
         dvd_in[k+1] = dvd_ff[k] << 1;
         tq_in[k+1] = tq_ff[k] << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIVIDEND_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= DIVIDEND_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff[0] <= {product, 16'b0};
         tq_ff[0] <= {{(DIVIDEND_W-ANGLE_W-16){1'b0}}, in_angle, 16'b0};
         rem_ff[0] <= '0;
         cmod_ff[0] <= '0;
         tmod_ff[0] <= '0;
         for (int k = 1; k <= DIVIDEND_W; k++) begin
            dvd_ff[k] <= dvd_in[k];
            tq_ff[k] <= tq_in[k];
            rem_ff[k] <= rem_in[k];
            cmod_ff[k] <= cmod_in[k];
            tmod_ff[k] <= tmod_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIVIDEND_W];
   assign out_phase_t = tmod_ff[DIVIDEND_W][MOD_W-1:2];
   assign out_phase_c = (rolling_radius == '0) ? '0 : cmod_ff[DIVIDEND_W][MOD_W-1:2];

endmodule

/* rtl/epg_cordic.sv */
// Quadrant fold and rotation-mode CORDIC, one register stage per iteration, giving
// cosine and sine of a phase in [0, 2*pi). Depends on epg_pkg.
module epg_cordic
   import epg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [PHASE_W-1:0]       in_phase,
   output logic                     out_valid,
   output logic signed [CORD_W-1:0] out_cos,
   output logic signed [CORD_W-1:0] out_sin
);

   logic                     valid_ff [0:CORDIC_STEPS];
   logic                     neg_ff   [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] x_ff     [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] y_ff     [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] z_ff     [0:CORDIC_STEPS];
   logic signed [CORD_W-1:0] x_in     [1:CORDIC_STEPS];
   logic signed [CORD_W-1:0] y_in     [1:CORDIC_STEPS];
   logic signed [CORD_W-1:0] z_in     [1:CORDIC_STEPS];

   logic                     out_valid_ff;
   logic signed [CORD_W-1:0] cos_ff;
   logic signed [CORD_W-1:0] sin_ff;

   logic signed [CORD_W-1:0] ang;
   logic signed [CORD_W-1:0] ang_wrap;
   logic signed [CORD_W-1:0] z_start;
   logic                     neg_start;

   always_comb begin
      ang = signed'({{(CORD_W-PHASE_W){1'b0}}, in_phase});
      ang_wrap = (ang > PI_Q30) ? ang - TWO_PI_Q30 : ang;
      if (ang_wrap > HALF_PI_Q30) begin
         z_start = ang_wrap - PI_Q30;
         neg_start = 1'b1;
      end else if (ang_wrap < -HALF_PI_Q30) begin
         z_start = ang_wrap + PI_Q30;
         neg_start = 1'b1;
      end else begin
         z_start = ang_wrap;
         neg_start = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_q30(i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_q30(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= INV_GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= z_start;
         neg_ff[0] <= neg_start;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            neg_ff[i] <= neg_ff[i-1];
         end
         cos_ff <= neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         sin_ff <= neg_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cos = cos_ff;
   assign out_sin = sin_ff;

endmodule

/* rtl/epg_combine.sv */
// Multiplies the two circle terms by their radii, subtracts and rounds to Q10.8.
// Holds the output register of the block. Depends on epg_pkg.
module epg_combine
   import epg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic signed [CORD_W-1:0]  cos_t,
   input  logic signed [CORD_W-1:0]  sin_t,
   input  logic signed [CORD_W-1:0]  cos_c,
   input  logic signed [CORD_W-1:0]  sin_c,
   input  logic [RADIUS_W-1:0]       rolling_radius,
   input  logic [SUM_W-1:0]          radius_sum,
   output logic                      out_valid,
   output logic signed [POINT_W-1:0] out_x,
   output logic signed [POINT_W-1:0] out_y
);

   logic                     valid_ff;
   logic signed [PROD_W-1:0] sx_ff;
   logic signed [PROD_W-1:0] ax_ff;
   logic signed [PROD_W-1:0] sy_ff;
   logic signed [PROD_W-1:0] ay_ff;
   logic                     out_valid_ff;
   logic signed [POINT_W-1:0] x_ff;
   logic signed [POINT_W-1:0] y_ff;

   logic signed [SUM_W:0]    s_signed;
   logic signed [SUM_W:0]    a_signed;
   logic signed [PROD_W:0]   x_sum;
   logic signed [PROD_W:0]   y_sum;

   assign s_signed = signed'({1'b0, radius_sum});
   assign a_signed = signed'({2'b0, rolling_radius});

   always_comb begin
      x_sum = PROD_W'(sx_ff) - PROD_W'(ax_ff) + (PROD_W+1)'(1 << 29);
      y_sum = PROD_W'(sy_ff) - PROD_W'(ay_ff) + (PROD_W+1)'(1 << 29);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
         out_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sx_ff <= PROD_W'(s_signed * cos_t);
         ax_ff <= PROD_W'(a_signed * cos_c);
         sy_ff <= PROD_W'(s_signed * sin_t);
         ay_ff <= PROD_W'(a_signed * sin_c);
         x_ff <= POINT_W'(x_sum >>> 30);
         y_ff <= POINT_W'(y_sum >>> 30);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;

endmodule

/* rtl/epicycloid_point_generator.sv */
// Top level of the epicycloid point generator: register port and pipeline glue.
// Depends on epg_pkg, epg_divmod, epg_cordic and epg_combine.
//
//   channel   ports                                   role
//   request   req_valid, req_ready, req_angle         angle t, unsigned Q11.16
//   response  rsp_valid, rsp_ready, rsp_point_x/y     point, signed Q10.8
//   csr       csr_psel ... csr_prdata, csr_pready     radii a (0x0) and b (0x4)
//
// One request is taken every cycle unless the response is stalled; with the default 16
// CORDIC steps its point passes 81 register stages: multiply, 60 divider bits, fold,
// steps, sign, 2 combine.
// Synchronous reset clears all valid bits and sets both radii to 1.0.
// When the response is stalled the whole pipeline holds and req_ready drops.
module epicycloid_point_generator
   import epg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ANGLE_W-1:0]        req_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POINT_W-1:0] rsp_point_x,
   output logic signed [POINT_W-1:0] rsp_point_y,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [RADIUS_W-1:0] rolling_ff;
   logic [RADIUS_W-1:0] fixed_ff;
   logic [SUM_W-1:0]    radius_sum;
   logic                enable;
   logic                csr_write;
   logic [1:0]          csr_index;

   logic                div_valid;
   logic [PHASE_W-1:0]  phase_t;
   logic [PHASE_W-1:0]  phase_c;
   logic                cord_t_valid;
   logic                cord_c_valid;
   logic signed [CORD_W-1:0] cos_t;
   logic signed [CORD_W-1:0] sin_t;
   logic signed [CORD_W-1:0] cos_c;
   logic signed [CORD_W-1:0] sin_c;

   assign enable = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign radius_sum = SUM_W'(rolling_ff) + SUM_W'(fixed_ff);

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = {1'b0, csr_paddr[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rolling_ff <= 16'd256;
         fixed_ff <= 16'd256;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROLLING: rolling_ff <= csr_pwdata[RADIUS_W-1:0];
            REG_FIXED: fixed_ff <= csr_pwdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROLLING: csr_prdata = {16'b0, rolling_ff};
         REG_FIXED: csr_prdata = {16'b0, fixed_ff};
         default: csr_prdata = '0;
      endcase
   end

   epg_divmod u_divmod (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_valid       (req_valid),
      .in_angle       (req_angle),
      .rolling_radius (rolling_ff),
      .radius_sum     (radius_sum),
      .out_valid      (div_valid),
      .out_phase_t    (phase_t),
      .out_phase_c    (phase_c)
   );

   epg_cordic u_cordic_t (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_valid),
      .in_phase  (phase_t),
      .out_valid (cord_t_valid),
      .out_cos   (cos_t),
      .out_sin   (sin_t)
   );

   epg_cordic u_cordic_c (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_valid),
      .in_phase  (phase_c),
      .out_valid (cord_c_valid),
      .out_cos   (cos_c),
      .out_sin   (sin_c)
   );

   epg_combine u_combine (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_valid       (cord_t_valid && cord_c_valid),
      .cos_t          (cos_t),
      .sin_t          (sin_t),
      .cos_c          (cos_c),
      .sin_c          (sin_c),
      .rolling_radius (rolling_ff),
      .radius_sum     (radius_sum),
      .out_valid      (rsp_valid),
      .out_x          (rsp_point_x),
      .out_y          (rsp_point_y)
   );

endmodule

/* tb/tb_top.sv */
// Testbench for the epicycloid point generator: drives angle requests and radius writes,
// and checks every point against a fixed-point model of the curve held here.
// Depends on epg_pkg and the epicycloid_point_generator RTL.
`timescale 1ns / 1ps

class point_scoreboard;
   localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint INV_GAIN_Q30 = 64'sd652032874;
   localparam longint ARCTAN_Q30 [24] = '{
      843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

   logic [15:0] rolling;
   logic [15:0] fixed_r;
   logic signed [18:0] want_x[$];
   logic signed [18:0] want_y[$];
   int errors;

   function new();
      rolling = 16'd256;
      fixed_r = 16'd256;
      errors = 0;
   endfunction

   function int pending();
      return want_x.size();
   endfunction

   function void rotate(input longint phase, output longint co, output longint si);
      longint x, y, z, dx, dy;
      bit flip;
      flip = 0;
      x = INV_GAIN_Q30;
      y = 0;
      if (phase > PI_Q30) phase -= TWO_PI_Q30;
      if (phase > HALF_PI_Q30) begin
         phase -= PI_Q30;
         flip = 1;
      end else if (phase < -HALF_PI_Q30) begin
         phase += PI_Q30;
         flip = 1;
      end
      z = phase;
      for (int i = 0; i < epg_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARCTAN_Q30[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARCTAN_Q30[i];
         end
      end
      co = flip ? -x : x;
      si = flip ? -y : y;
   endfunction

   function logic signed [18:0] round_q8(input longint q38);
      longint r;
      r = (q38 + (64'sd1 <<< 29)) >>> 30;
      return r[18:0];
   endfunction

   function void note_request(input logic [26:0] angle);
      longint unsigned a, s, tq, cq;
      longint ct, st, cc, sc;
      a = rolling;
      s = a + fixed_r;
      tq = longint'(angle) << 16;
      cq = (a != 0) ? (s * tq) / a : 0;
      rotate(longint'((tq % TWO_PI_Q32) >> 2), ct, st);
      rotate(longint'((cq % TWO_PI_Q32) >> 2), cc, sc);
      want_x.push_back(round_q8(longint'(s) * ct - longint'(a) * cc));
      want_y.push_back(round_q8(longint'(s) * st - longint'(a) * sc));
   endfunction

   function void check_point(input logic signed [18:0] x, input logic signed [18:0] y);
      if (want_x.size() == 0) begin
         $error("point (%0d, %0d) arrived with no request outstanding", x, y);
         errors++;
         return;
      end
      if (x !== want_x[0]) begin
         $error("point_x expected %0d actual %0d", want_x[0], x);
         errors++;
      end
      if (y !== want_y[0]) begin
         $error("point_y expected %0d actual %0d", want_y[0], y);
         errors++;
      end
      void'(want_x.pop_front());
      void'(want_y.pop_front());
   endfunction
endclass

module tb_top;
   import epg_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [ANGLE_W-1:0] req_angle;
   logic signed [POINT_W-1:0] rsp_point_x, rsp_point_y;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   int sender_idle_pct, receiver_idle_pct;
   point_scoreboard curve;

   epicycloid_point_generator DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) curve.note_request(req_angle);
         if (rsp_valid && rsp_ready) curve.check_point(rsp_point_x, rsp_point_y);
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);

   task automatic write_radius(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {index[0], 2'b00};
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (index == REG_ROLLING) curve.rolling = value;
      else curve.fixed_r = value;
   endtask

   task automatic send_angle(input logic [ANGLE_W-1:0] angle);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_angle <= angle;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (curve.pending() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      case ($urandom_range(3))
         0: return ANGLE_W'($urandom_range(0, 411774));
         1: return ANGLE_W'($urandom_range(0, 2 ** ANGLE_W - 1));
         2: return {ANGLE_W{1'b1}} >> $urandom_range(0, ANGLE_W - 1);
         default: return ANGLE_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] rolling_set[6] = '{16'd256, 16'd1, 16'd65535, 16'd1, 16'd65535, 16'd777};
      logic [15:0] fixed_set[6] = '{16'd256, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd1234};
      logic [ANGLE_W-1:0] directed[14] = '{0, 1, 102944, 102943, 205887, 205888, 308831,
         411774, 411775, 65536, 2 ** ANGLE_W - 1, 2 ** (ANGLE_W - 1), 27'h2AAAAAA, 27'h5555555};
      curve = new();
      reset = 1;
      req_valid = 0;
      req_angle = 0;
      rsp_ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i]) send_angle(directed[i]);
      drain();
      write_radius(REG_ROLLING, 16'd0);
      write_radius(REG_FIXED, 16'd512);
      foreach (directed[i]) if (i < 8) send_angle(directed[i]);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 54 : 0;
         receiver_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 36 : 0;
         write_radius(REG_ROLLING, rolling_set[phase]);
         write_radius(REG_FIXED, fixed_set[phase]);
         for (int n = 0; n < 125; n++) begin
            if (phase == 1 && n == 60) drain();
            send_angle(random_angle());
         end
         drain();
      end

      if (curve.errors == 0 && curve.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
